### rtl/bker_pkg.sv
// ----------------------------------------------------------------------------
// bker_pkg
// Shared types and constants for the broadcast key event rings.
// ----------------------------------------------------------------------------
package bker_pkg;

  localparam int READERS_DEF = 8;
  localparam int DEPTH_DEF   = 64;

  localparam int KEY_W    = 8;
  localparam int READER_W = 3;
  localparam int KIND_W   = 2;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [READER_W-1:0] reader_t;
  typedef logic [KEY_W-1:0]    key_t;

  localparam kind_t KIND_EVENT = 2'd0;
  localparam kind_t KIND_READ  = 2'd1;
  localparam kind_t KIND_OPEN  = 2'd2;
  localparam kind_t KIND_CLOSE = 2'd3;

  // stored entry: action in the high byte, key in the low byte
  typedef struct packed {
    key_t action;
    key_t key;
  } event_t;

endpackage

### rtl/bker_if.sv
// ----------------------------------------------------------------------------
// bker_if
// Request and response channels of the broadcast key event rings.
// ----------------------------------------------------------------------------
interface bker_req_if;
  logic                valid;
  logic                ready;
  bker_pkg::kind_t     kind;
  bker_pkg::reader_t   reader;
  bker_pkg::key_t      key_code;
  bker_pkg::key_t      key_action;

  modport source (output valid, kind, reader, key_code, key_action, input ready);
  modport sink   (input valid, kind, reader, key_code, key_action, output ready);
endinterface

interface bker_rsp_if;
  logic                valid;
  logic                ready;
  logic                event_valid;
  bker_pkg::key_t      out_key;
  bker_pkg::key_t      out_action;
  logic                open_ok;
  bker_pkg::reader_t   open_slot;

  modport source (output valid, event_valid, out_key, out_action, open_ok, open_slot,
                  input ready);
  modport sink   (input valid, event_valid, out_key, out_action, open_ok, open_slot,
                  output ready);
endinterface

### rtl/bker_bank.sv
// ----------------------------------------------------------------------------
// bker_bank
// Event ring storage of one reader slot: one write port, one registered read.
// ----------------------------------------------------------------------------
module bker_bank #(
  parameter int DEPTH = bker_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  bker_pkg::event_t           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output bker_pkg::event_t           rdata
);
  import bker_pkg::*;

  event_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/broadcast_key_event_rings_top.sv
// ----------------------------------------------------------------------------
// broadcast_key_event_rings_top
// Reader slots with private key event rings; events go to all open readers.
// ----------------------------------------------------------------------------
// The block takes one request per clock unless the response side stalls,
// and answers every request with exactly one response, registered after
// a middle stage that waits for the registered read port of the per-slot ring
// banks. Requests: key event (stored in the ring of every claimed slot at
// once, one bank per slot), read (pops the oldest event of one slot or
// reports empty), open (claims the lowest free slot and clears its
// pointers), close (frees a slot). Slot 0 is claimed out of reset. Rings have
// no full check: more than DEPTH unread events overwrite the backlog. Ring
// contents are not cleared by reset; pointers and claim bits are.
// ----------------------------------------------------------------------------
module broadcast_key_event_rings_top #(
  parameter int READERS = bker_pkg::READERS_DEF,
  parameter int DEPTH   = bker_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bker_req_if.sink   req,
  bker_rsp_if.source rsp
);
  import bker_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);              // pointer runs 0..DEPTH
  localparam int IW = $clog2(DEPTH);                  // ring index
  localparam int SW = (READERS > 1) ? $clog2(READERS) : 1;

  // slot state
  logic [READERS-1:0] claimed;
  logic [PW-1:0]      rp [READERS];
  logic [PW-1:0]      wp [READERS];

  // wrapped pointers, ready for use
  logic [PW-1:0]      rp_eff [READERS];
  logic [PW-1:0]      wp_eff [READERS];

  // request decode
  logic               accept;
  logic               adv;
  logic               is_event;
  logic               is_read;
  logic               is_open;
  logic               is_close;
  logic               hit;
  logic [SW-1:0]      sel;
  logic               pop_ok;
  logic               free_found;
  logic [SW-1:0]      free_idx;
  logic [PW-1:0]      rp_sel;

  // bank ports
  logic [READERS-1:0] bank_we;
  logic [READERS-1:0] bank_re;
  event_t             bank_rd [READERS];
  event_t             wdata;

  // middle stage: waits for the bank read data
  logic               s1_valid;
  logic               s1_pop;
  logic [SW-1:0]      s1_sel;
  logic               s1_open_ok;
  reader_t            s1_open_slot;

  // handshake: output register frees, middle stage moves, new request enters
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = !s1_valid || adv;
  assign accept    = req.valid && req.ready;

  assign wdata.action = req.key_action;
  assign wdata.key    = req.key_code;

  always_comb begin
    for (int s = 0; s < READERS; s++) begin
      rp_eff[s] = (rp[s] >= PW'(DEPTH)) ? '0 : rp[s];
      wp_eff[s] = (wp[s] >= PW'(DEPTH)) ? '0 : wp[s];
    end
  end

  always_comb begin
    is_event = 1'b0;
    is_read  = 1'b0;
    is_open  = 1'b0;
    is_close = 1'b0;
    unique case (req.kind)
      KIND_EVENT: is_event = 1'b1;
      KIND_READ:  is_read  = 1'b1;
      KIND_OPEN:  is_open  = 1'b1;
      KIND_CLOSE: is_close = 1'b1;
      default:    is_event = 1'b0;
    endcase
  end

  // reader field may exceed the slot count; such a slot reads empty
  assign hit    = 32'(req.reader) < 32'(READERS);
  assign sel    = SW'(req.reader);
  assign rp_sel = rp_eff[sel];
  assign pop_ok = hit && claimed[sel] && (rp[sel] != wp[sel]);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = READERS - 1; s >= 0; s--) begin
      if (!claimed[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
    end
  end

  always_comb begin
    for (int s = 0; s < READERS; s++) begin
      bank_we[s] = accept && is_event && claimed[s];
      bank_re[s] = accept && is_read && pop_ok && (sel == SW'(s));
    end
  end

  for (genvar g = 0; g < READERS; g++) begin : g_bank
    bker_bank #(
      .DEPTH (DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (wp_eff[g][IW-1:0]),
      .wdata (wdata),
      .re    (bank_re[g]),
      .raddr (rp_sel[IW-1:0]),
      .rdata (bank_rd[g])
    );
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      claimed <= READERS'(1);
      for (int s = 0; s < READERS; s++) begin
        rp[s] <= '0;
        wp[s] <= '0;
      end
    end else if (accept) begin
      for (int s = 0; s < READERS; s++) begin
        if (bank_we[s]) begin
          wp[s] <= wp_eff[s] + PW'(1);
        end
        if (bank_re[s]) begin
          rp[s] <= rp_eff[s] + PW'(1);
        end
      end
      if (is_open && free_found) begin
        claimed[free_idx] <= 1'b1;
        rp[free_idx]      <= '0;
        wp[free_idx]      <= '0;
      end
      if (is_close && hit) begin
        claimed[sel] <= 1'b0;
      end
    end
  end

  // middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pop       <= is_read && pop_ok;
      s1_sel       <= sel;
      s1_open_ok   <= is_open && free_found;
      s1_open_slot <= (is_open && free_found) ? READER_W'(free_idx) : '0;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      rsp.event_valid <= s1_pop;
      rsp.out_key     <= s1_pop ? bank_rd[s1_sel].key : '0;
      rsp.out_action  <= s1_pop ? bank_rd[s1_sel].action : '0;
      rsp.open_ok     <= s1_open_ok;
      rsp.open_slot   <= s1_open_slot;
    end
  end

endmodule

### test/bker_rings_checker.sv
// ----------------------------------------------------------------------------
// bker_rings_checker
// Watches the request and response channels of the key event rings, keeps
// its own copy of the slots and rings, predicts one response per accepted
// request and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module bker_rings_checker #(
  parameter int READERS = bker_pkg::READERS_DEF,
  parameter int DEPTH   = bker_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  bker_req_if  req,
  bker_rsp_if  rsp,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import bker_pkg::*;

  localparam int PTR_W      = $clog2(DEPTH + 1);
  localparam int REPORT_MAX = 10;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic    event_valid;
    key_t    out_key;
    key_t    out_action;
    logic    open_ok;
    reader_t open_slot;
  } reply_t;

  logic   claimed [READERS];
  ptr_t   rd_ptr  [READERS];
  ptr_t   wr_ptr  [READERS];
  event_t ring    [READERS][DEPTH];
  reply_t awaited_replies [$];
  int     mismatch_count;

  // applies one request to the slot state, returns the response it earns
  function automatic reply_t step_rings(kind_t kind, reader_t reader, key_t code,
                                        key_t action);
    reply_t rep;
    event_t ev;
    bit     found;
    rep   = '0;
    found = 1'b0;
    case (kind)
      KIND_EVENT: begin
        ev.key    = code;
        ev.action = action;
        for (int s = 0; s < READERS; s++) begin
          if (claimed[s]) begin
            if (wr_ptr[s] >= DEPTH) wr_ptr[s] = '0;
            ring[s][wr_ptr[s]] = ev;
            wr_ptr[s] = wr_ptr[s] + 1'b1;
          end
        end
      end
      KIND_READ: begin
        if (int'(reader) < READERS && claimed[reader] &&
            rd_ptr[reader] != wr_ptr[reader]) begin
          if (rd_ptr[reader] >= DEPTH) rd_ptr[reader] = '0;
          ev = ring[reader][rd_ptr[reader]];
          rd_ptr[reader]  = rd_ptr[reader] + 1'b1;
          rep.event_valid = 1'b1;
          rep.out_key     = ev.key;
          rep.out_action  = ev.action;
        end
      end
      KIND_OPEN: begin
        for (int s = 0; s < READERS; s++) begin
          if (!found && !claimed[s]) begin
            found         = 1'b1;
            claimed[s]    = 1'b1;
            rd_ptr[s]     = '0;
            wr_ptr[s]     = '0;
            rep.open_ok   = 1'b1;
            rep.open_slot = reader_t'(s);
          end
        end
      end
      default: begin
        if (int'(reader) < READERS) claimed[reader] = 1'b0;
      end
    endcase
    return rep;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int s = 0; s < READERS; s++) begin
        claimed[s] = (s == 0);
        rd_ptr[s]  = '0;
        wr_ptr[s]  = '0;
      end
      awaited_replies.delete();
    end else begin
      if (req.valid && req.ready)
        awaited_replies.push_back(step_rings(req.kind, req.reader, req.key_code,
                                             req.key_action));
      if (rsp.valid && rsp.ready) begin
        got.event_valid = rsp.event_valid;
        got.out_key     = rsp.out_key;
        got.out_action  = rsp.out_action;
        got.open_ok     = rsp.open_ok;
        got.open_slot   = rsp.open_slot;
        if (awaited_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected response: ev=%0b key=%h act=%h ok=%0b slot=%0d",
                     $realtime, got.event_valid, got.out_key, got.out_action,
                     got.open_ok, got.open_slot);
        end else begin
          want = awaited_replies.pop_front();
          if (got.event_valid !== want.event_valid || got.out_key !== want.out_key ||
              got.out_action !== want.out_action || got.open_ok !== want.open_ok ||
              got.open_slot !== want.open_slot) begin
            mismatch_count++;
            // fields: event_valid/key/action/open_ok/open_slot
            if (mismatch_count <= REPORT_MAX)
              $display("%0t: mismatch exp %0b/%h/%h/%0b/%0d got %0b/%h/%h/%0b/%0d",
                       $realtime, want.event_valid, want.out_key, want.out_action,
                       want.open_ok, want.open_slot, got.event_valid, got.out_key,
                       got.out_action, got.open_ok, got.open_slot);
          end
        end
      end
    end
    fails   <= mismatch_count;
    pending <= awaited_replies.size();
  end

endmodule

### test/tb_broadcast_key_event_rings_top.sv
// ----------------------------------------------------------------------------
// tb_broadcast_key_event_rings_top
// Drives requests into the key event rings under several idle and stall
// mixes; a side checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_broadcast_key_event_rings_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bker_pkg::*;

  localparam int READERS         = READERS_DEF;
  localparam int DEPTH           = DEPTH_DEF;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int DRAIN_CYCLES    = 10;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 4;

  // phase mix: none, sender idle, receiver stall, both lightly
  localparam int IDLE_PCT  [PHASES] = '{0, 86, 0, 17};
  localparam int STALL_PCT [PHASES] = '{0, 0, 86, 17};

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   requests_issued;
  int   cycle_count;

  bker_req_if req ();
  bker_rsp_if rsp ();

  broadcast_key_event_rings_top #(
    .READERS (READERS),
    .DEPTH   (DEPTH)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bker_rings_checker #(
    .READERS (READERS),
    .DEPTH   (DEPTH)
  ) i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: per-cycle random stall at the current phase rate
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: a hang or a lost response ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One request. Idle gaps come before valid rises, so valid is never lowered
  // and raised in the same step; it stays high across back-to-back requests.
  task automatic issue_request(input kind_t kind, input reader_t reader,
                               input key_t code, input key_t action);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.reader     <= reader;
    req.key_code   <= code;
    req.key_action <= action;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    requests_issued++;
  endtask

  // fields that the kind ignores still get random values
  task automatic issue_noisy(input kind_t kind, input reader_t reader);
    issue_request(kind, reader, key_t'($urandom_range(255)), key_t'($urandom_range(255)));
  endtask

  // Stop sending and wait until every predicted response has arrived. The
  // extra edge lets the checker count the last accepted request first.
  task automatic wait_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random traffic in short sequences: event bursts, read bursts that drain a
  // slot, opens and closes, single noise requests, and now and then a long
  // event run that laps a ring followed by a long drain of one slot.
  task automatic random_burst();
    int      pick;
    int      len;
    reader_t slot;
    pick = $urandom_range(19);
    slot = reader_t'($urandom_range(7));
    if (pick <= 7) begin
      len = $urandom_range(1, 6);
      repeat (len) issue_noisy(KIND_EVENT, slot);
    end else if (pick <= 13) begin
      len = $urandom_range(1, 8);
      repeat (len) issue_noisy(KIND_READ, slot);
    end else if (pick <= 15) begin
      len = $urandom_range(1, 2);
      repeat (len) issue_noisy(KIND_OPEN, reader_t'($urandom_range(7)));
    end else if (pick <= 17) begin
      issue_noisy(KIND_CLOSE, slot);
    end else if (pick == 18) begin
      issue_noisy(kind_t'($urandom_range(3)), slot);
    end else begin
      // overflow: more than DEPTH unread events, then read back what is left
      len = $urandom_range(DEPTH + 1, DEPTH + 8);
      repeat (len) issue_noisy(KIND_EVENT, reader_t'($urandom_range(7)));
      len = $urandom_range(1, DEPTH + 8);
      repeat (len) issue_noisy(KIND_READ, slot);
    end
  endtask

  initial begin
    int target;
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.kind       <= KIND_EVENT;
    req.reader     <= '0;
    req.key_code   <= '0;
    req.key_action <= '0;
    recv_stall_pct <= 0;
    send_idle_pct  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: main reader empty, unclaimed slot read and close
    issue_request(KIND_READ,  3'd0, 8'h00, 8'h00);
    issue_request(KIND_READ,  3'd5, 8'hFF, 8'hFF);
    issue_request(KIND_CLOSE, 3'd6, 8'h00, 8'h00);
    // extreme key values, then read them back and hit empty again
    issue_request(KIND_EVENT, 3'd7, 8'h00, 8'h00);
    issue_request(KIND_EVENT, 3'd0, 8'hFF, 8'hFF);
    issue_request(KIND_READ,  3'd0, 8'h00, 8'h00);
    issue_request(KIND_READ,  3'd0, 8'h00, 8'h00);
    issue_request(KIND_READ,  3'd0, 8'h00, 8'h00);
    // claim every slot; the eighth open finds none free
    repeat (8) issue_request(KIND_OPEN, 3'd7, 8'hFF, 8'hFF);
    // broadcast to all slots, read the last one
    issue_request(KIND_EVENT, 3'd0, 8'hA5, 8'h5A);
    issue_request(KIND_READ,  3'd7, 8'h00, 8'h00);
    // main reader can be closed and reopened with cleared pointers
    issue_request(KIND_CLOSE, 3'd0, 8'h00, 8'h00);
    issue_request(KIND_OPEN,  3'd0, 8'h00, 8'h00);
    issue_request(KIND_READ,  3'd0, 8'h00, 8'h00);
    // closed slot misses the broadcast and reads empty; an open one keeps order
    issue_request(KIND_CLOSE, 3'd3, 8'h00, 8'h00);
    issue_request(KIND_EVENT, 3'd3, 8'h3C, 8'hC3);
    issue_request(KIND_READ,  3'd3, 8'h00, 8'h00);
    issue_request(KIND_READ,  3'd4, 8'h00, 8'h00);
    wait_until_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = IDLE_PCT[p];
      recv_stall_pct <= STALL_PCT[p];
      target = requests_issued + ITEMS_PER_PHASE;
      while (requests_issued < target) random_burst();
      // sender holds off until every response is back
      wait_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
